### src/fpr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO page replacement package
// Shared sizes, constants and the cell chain record for the page replacement
// block.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int FRAMES    = 8;
  localparam int PAGE_BITS = 16;
  localparam int SLOT_W    = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int FCNT_W    = $clog2(FRAMES + 1);
  localparam int CFG_W     = 4;
  localparam int CNT_W     = 32;
  localparam int OSLOT_W   = 3;
  localparam int OPAGE_W   = 16;
  localparam int IN_DATA_W = ((PAGE_BITS + 7) / 8) * 8;
  localparam int OUT_BITS  = OSLOT_W + 1 + OPAGE_W + 2 * CNT_W;
  localparam int OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  typedef struct packed {
    logic                 found;
    logic [SLOT_W-1:0]    hit_slot;
    logic [SLOT_W-1:0]    idx;
    logic                 ev_valid;
    logic [PAGE_BITS-1:0] ev_page;
  } chain_t;

endpackage

### src/fpr_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame cell
// Holds one resident page, compares it against the request and passes the
// lookup and eviction results on to the next cell.
// ----------------------------------------------------------------------------
module fpr_cell (
  input  logic                           clk,
  input  logic                           rst_n,
  input  fpr_pkg::chain_t                chain_i,
  input  logic [fpr_pkg::PAGE_BITS-1:0]  page_i,
  input  logic [fpr_pkg::SLOT_W-1:0]     sel_slot_i,
  input  logic                           wr_en_i,
  input  logic [fpr_pkg::SLOT_W-1:0]     wr_slot_i,
  input  logic                           clr_i,
  output fpr_pkg::chain_t                chain_o
);

  logic [fpr_pkg::PAGE_BITS-1:0] page_r;
  logic                          valid_r;
  logic                          match;
  logic                          sel;
  logic                          wr_here;

  assign match   = valid_r && (page_r == page_i);
  assign sel     = valid_r && (chain_i.idx == sel_slot_i);
  assign wr_here = wr_en_i && (chain_i.idx == wr_slot_i);

  always_comb begin
    chain_o.found    = chain_i.found | match;
    chain_o.hit_slot = (!chain_i.found && match) ? chain_i.idx : chain_i.hit_slot;
    chain_o.idx      = chain_i.idx + fpr_pkg::SLOT_W'(1);
    chain_o.ev_valid = chain_i.ev_valid | sel;
    chain_o.ev_page  = chain_i.ev_page | (sel ? page_r : '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (clr_i) begin
      valid_r <= 1'b0;
    end else if (wr_here) begin
      valid_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_here) begin
      page_r <= page_i;
    end
  end

endmodule

### src/fpr_sat_cnt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Saturating event counter
// Counts events up to the all-ones value and reports the updated count.
// ----------------------------------------------------------------------------
module fpr_sat_cnt (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       inc_i,
  input  logic                       clr_i,
  output logic [fpr_pkg::CNT_W-1:0]  cnt_o
);

  logic [fpr_pkg::CNT_W-1:0] cnt_r;
  logic [fpr_pkg::CNT_W-1:0] cnt_nxt;

  always_comb begin
    cnt_nxt = cnt_r;
    if (inc_i && (cnt_r != '1)) begin
      cnt_nxt = cnt_r + fpr_pkg::CNT_W'(1);
    end
  end

  assign cnt_o = cnt_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (clr_i) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

endmodule

### src/fifo_page_replacement_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// FIFO page replacement
// Fully associative frame set with in-order fill and round-robin replacement.
// ----------------------------------------------------------------------------
// The block takes one page reference per clock and returns its result in the
// cycle after acceptance; the lookup runs through a row of eight frame cells
// in the accepting cycle. The result sits in one output register, so a new request
// enters only in a cycle where that register is empty or being read; while a
// result is held back, the input stalls. A request with tlast set ends the
// string: its result carries the final counts, and afterwards the frames and
// counters start empty.
module fifo_page_replacement_top (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            cfg_we,
  input  logic [fpr_pkg::CFG_W-1:0]       cfg_wdata,
  input  logic                            in_tvalid,
  output logic                            in_tready,
  input  logic [fpr_pkg::IN_DATA_W-1:0]   in_tdata,   // page
  input  logic                            in_tlast,
  output logic                            out_tvalid,
  input  logic                            out_tready,
  output logic [fpr_pkg::OUT_DATA_W-1:0]  out_tdata,  // slot, evicted_valid,
                                                      // evicted_page, fault_count,
                                                      // hit_count, zero pad
  output logic                            out_tuser,  // hit
  output logic                            out_tlast
);

  localparam int NF = fpr_pkg::FRAMES;
  localparam int SW = fpr_pkg::SLOT_W;
  localparam int FW = fpr_pkg::FCNT_W;

  logic [fpr_pkg::CFG_W-1:0]      frames_in_use_r;
  logic [FW-1:0]                  filled_r;
  logic [FW-1:0]                  filled_nxt;
  logic [SW-1:0]                  ptr_r;
  logic [SW-1:0]                  ptr_nxt;
  logic [FW-1:0]                  eff;
  logic [FW-1:0]                  repl_plus;
  logic [SW-1:0]                  repl_slot;
  logic [SW-1:0]                  wr_slot;
  logic                           fill_mode;
  logic                           in_acc;
  logic                           miss;
  logic                           clr;
  logic [fpr_pkg::PAGE_BITS-1:0]  page;
  logic                           ev_valid;
  logic [fpr_pkg::PAGE_BITS-1:0]  ev_page;
  logic [SW-1:0]                  res_slot;
  logic [fpr_pkg::CNT_W-1:0]      fault_cnt;
  logic [fpr_pkg::CNT_W-1:0]      hit_cnt;
  fpr_pkg::chain_t                chain [NF+1];

  logic                           out_valid_r;
  logic                           out_hit_r;
  logic [fpr_pkg::OSLOT_W-1:0]    out_slot_r;
  logic                           out_ev_valid_r;
  logic [fpr_pkg::OPAGE_W-1:0]    out_ev_page_r;
  logic [fpr_pkg::CNT_W-1:0]      out_faults_r;
  logic [fpr_pkg::CNT_W-1:0]      out_hits_r;
  logic                           out_last_r;

  assign in_tready = !out_valid_r || out_tready;
  assign in_acc    = in_tvalid && in_tready;
  assign page      = in_tdata[fpr_pkg::PAGE_BITS-1:0];
  assign clr       = in_acc && in_tlast;

  always_comb begin
    if (frames_in_use_r == '0) begin
      eff = FW'(1);
    end else if (32'(frames_in_use_r) > NF) begin
      eff = FW'(NF);
    end else begin
      eff = FW'(frames_in_use_r);
    end
  end

  assign fill_mode = filled_r < eff;
  assign repl_slot = (FW'(ptr_r) < eff) ? ptr_r : '0;
  assign repl_plus = FW'(repl_slot) + FW'(1);
  assign wr_slot   = fill_mode ? SW'(filled_r) : repl_slot;

  assign chain[0] = '0;

  for (genvar g = 0; g < NF; g++) begin : g_cell
    fpr_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .chain_i    (chain[g]),
      .page_i     (page),
      .sel_slot_i (repl_slot),
      .wr_en_i    (in_acc && miss),
      .wr_slot_i  (wr_slot),
      .clr_i      (clr),
      .chain_o    (chain[g+1])
    );
  end

  assign miss     = !chain[NF].found;
  assign ev_valid = miss && !fill_mode && chain[NF].ev_valid;
  assign ev_page  = ev_valid ? chain[NF].ev_page : '0;
  assign res_slot = miss ? wr_slot : chain[NF].hit_slot;

  always_comb begin
    filled_nxt = filled_r;
    ptr_nxt    = ptr_r;
    if (miss) begin
      if (fill_mode) begin
        filled_nxt = filled_r + FW'(1);
      end else begin
        ptr_nxt = (repl_plus >= eff) ? '0 : SW'(repl_plus);
      end
    end
  end

  fpr_sat_cnt u_faults (
    .clk   (clk),
    .rst_n (rst_n),
    .inc_i (in_acc && miss),
    .clr_i (clr),
    .cnt_o (fault_cnt)
  );

  fpr_sat_cnt u_hits (
    .clk   (clk),
    .rst_n (rst_n),
    .inc_i (in_acc && !miss),
    .clr_i (clr),
    .cnt_o (hit_cnt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frames_in_use_r <= fpr_pkg::CFG_W'(NF);
    end else if (cfg_we) begin
      frames_in_use_r <= cfg_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      filled_r <= '0;
      ptr_r    <= '0;
    end else if (clr) begin
      filled_r <= '0;
      ptr_r    <= '0;
    end else if (in_acc) begin
      filled_r <= filled_nxt;
      ptr_r    <= ptr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_hit_r      <= !miss;
      out_slot_r     <= fpr_pkg::OSLOT_W'(res_slot);
      out_ev_valid_r <= ev_valid;
      out_ev_page_r  <= fpr_pkg::OPAGE_W'(ev_page);
      out_faults_r   <= fault_cnt;
      out_hits_r     <= hit_cnt;
      out_last_r     <= in_tlast;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_hit_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = fpr_pkg::OUT_DATA_W'({out_hits_r, out_faults_r, out_ev_page_r,
                                            out_ev_valid_r, out_slot_r});

`ifndef NO_ASSERTIONS
  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_tlast |=> filled_r == '0 && ptr_r == '0)
    else $error("Fill count or pointer not cleared after the last request.");

  a_filled_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(filled_r) <= NF)
    else $error("Fill count exceeds the number of frames.");

  a_hit_no_evict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_hit_r |-> !out_ev_valid_r && out_ev_page_r == '0)
    else $error("A hit reported an eviction.");

  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_tready |-> !in_tready)
    else $error("Request accepted while a result is stalled.");
`endif

endmodule
